// File: design/fpdx_pkg.sv
// Shared types and constants for the framed packet decoder with XOR checksum.
// No dependencies; fpdx_if, fpdx_decode, fpdx_out_reg and the top level import this package.
package fpdx_pkg;

  localparam logic [7:0] START_BYTE = 8'h02;
  localparam logic [7:0] END_BYTE   = 8'h03;

  typedef enum logic {
    KIND_PAYLOAD = 1'b0,
    KIND_VERDICT = 1'b1
  } result_kind_t;

  typedef struct packed {
    result_kind_t kind;
    logic [7:0]   data_byte;
    logic [7:0]   byte_index;
    logic         frame_ok;
  } result_t;

endpackage

// File: design/fpdx_if.sv
// Channel interfaces: received-byte stream and decoded-result stream.
// Depends on fpdx_pkg for the result kind type.
interface fpdx_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface fpdx_result_if
  import fpdx_pkg::*;
;
  logic         valid;
  logic         ready;
  result_kind_t result_kind;
  logic [7:0]   data_byte;
  logic [7:0]   byte_index;
  logic         frame_ok;

  modport source (output valid, output result_kind, output data_byte,
                  output byte_index, output frame_ok, input ready);
  modport sink   (input valid, input result_kind, input data_byte,
                  input byte_index, input frame_ok, output ready);
endinterface

// File: design/fpdx_in_reg.sv
// Input register stage: captures one received byte per transaction.
// Depends on fpdx_if for the input channel.
module fpdx_in_reg (
  input  logic        clk,
  input  logic        rst_n,
  fpdx_byte_if.sink   in_ch,
  input  logic        take,
  output logic        byte_valid,
  output logic [7:0]  byte_data
);

  logic       valid_r;
  logic       valid_nxt;
  logic [7:0] byte_r;

  // Refill in the same cycle the held byte is consumed.
  assign in_ch.ready = !valid_r || take;
  assign valid_nxt   = in_ch.valid ? 1'b1 : (valid_r && !take);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    if (in_ch.valid && in_ch.ready) begin
      byte_r <= in_ch.rx_byte;
    end
  end

  assign byte_valid = valid_r;
  assign byte_data  = byte_r;

endmodule

// File: design/fpdx_decode.sv
// Frame state machine: length, payload streaming, XOR check and verdict.
// Depends on fpdx_pkg for constants and the result struct.
module fpdx_decode
  import fpdx_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        byte_valid,
  input  logic [7:0]  byte_data,
  output logic        take,
  output logic        res_valid,
  input  logic        res_ready,
  output result_t     res
);

  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_LENGTH   = 3'd1,
    PH_PAYLOAD  = 3'd2,
    PH_CHECKSUM = 3'd3,
    PH_TERM     = 3'd4
  } phase_t;

  phase_t     phase_r, phase_nxt;
  logic [7:0] len_r, len_nxt;
  logic [7:0] cnt_r, cnt_nxt;
  logic [7:0] xor_r, xor_nxt;
  logic [7:0] csum_r, csum_nxt;
  logic       has_result;
  logic [7:0] cnt_inc;

  assign cnt_inc = cnt_r + 8'd1;

  always_comb begin
    phase_nxt      = phase_r;
    len_nxt        = len_r;
    cnt_nxt        = cnt_r;
    xor_nxt        = xor_r;
    csum_nxt       = csum_r;
    has_result     = 1'b0;
    res.kind       = KIND_PAYLOAD;
    res.data_byte  = 8'd0;
    res.byte_index = 8'd0;
    res.frame_ok   = 1'b0;
    case (phase_r)
      PH_LENGTH: begin
        len_nxt   = byte_data;
        cnt_nxt   = 8'd0;
        xor_nxt   = 8'd0;
        phase_nxt = (byte_data == 8'd0) ? PH_CHECKSUM : PH_PAYLOAD;
      end
      PH_PAYLOAD: begin
        has_result     = 1'b1;
        res.data_byte  = byte_data;
        res.byte_index = cnt_r;
        xor_nxt        = xor_r ^ byte_data;
        cnt_nxt        = cnt_inc;
        if (cnt_inc == len_r) begin
          phase_nxt = PH_CHECKSUM;
        end
      end
      PH_CHECKSUM: begin
        csum_nxt  = byte_data;
        phase_nxt = PH_TERM;
      end
      PH_TERM: begin
        has_result     = 1'b1;
        res.kind       = KIND_VERDICT;
        res.byte_index = len_r;
        res.frame_ok   = (byte_data == END_BYTE) && (csum_r == xor_r);
        phase_nxt      = PH_IDLE;
      end
      default: begin
        phase_nxt = (byte_data == START_BYTE) ? PH_LENGTH : PH_IDLE;
      end
    endcase
  end

  // Bytes without a result never wait on the output side.
  assign take      = byte_valid && (!has_result || res_ready);
  assign res_valid = byte_valid && has_result;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      len_r   <= 8'd0;
      cnt_r   <= 8'd0;
      xor_r   <= 8'd0;
      csum_r  <= 8'd0;
    end else if (take) begin
      phase_r <= phase_nxt;
      len_r   <= len_nxt;
      cnt_r   <= cnt_nxt;
      xor_r   <= xor_nxt;
      csum_r  <= csum_nxt;
    end
  end

endmodule

// File: design/fpdx_out_reg.sv
// Result register: holds one decoded result until the sink takes it.
// Depends on fpdx_pkg and fpdx_if.
module fpdx_out_reg
  import fpdx_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          res_valid,
  output logic          res_ready,
  input  result_t       res,
  fpdx_result_if.source out_ch
);

  logic    valid_r;
  logic    valid_nxt;
  result_t res_r;

  assign res_ready = !valid_r || out_ch.ready;
  assign valid_nxt = res_valid ? 1'b1 : (valid_r && !out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    if (res_valid && res_ready) begin
      res_r <= res;
    end
  end

  assign out_ch.valid       = valid_r;
  assign out_ch.result_kind = res_r.kind;
  assign out_ch.data_byte   = res_r.data_byte;
  assign out_ch.byte_index  = res_r.byte_index;
  assign out_ch.frame_ok    = res_r.frame_ok;

endmodule

// File: design/framed_packet_decoder_xor.sv
// Top level of the length-prefixed frame decoder with XOR checksum.
// Depends on fpdx_pkg, fpdx_if, fpdx_in_reg, fpdx_decode and fpdx_out_reg.
//
//   channel  direction  payload                                      handshake
//   in_ch    sink       rx_byte[7:0]                                 valid/ready
//   out_ch   source     result_kind, data_byte, byte_index, frame_ok valid/ready
//
// One byte per cycle while the output is not stalled; a result passes the input
// register, then the result register, before it is offered.
// Synchronous active-low reset puts the decoder back to waiting for a start byte.
// A stalled output holds only bytes that produce a result; start, length,
// checksum and idle bytes drain through regardless.
module framed_packet_decoder_xor
  import fpdx_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  fpdx_byte_if.sink     in_ch,
  fpdx_result_if.source out_ch
);

  logic       take;
  logic       byte_valid;
  logic [7:0] byte_data;
  logic       res_valid;
  logic       res_ready;
  result_t    res;

  fpdx_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .take       (take),
    .byte_valid (byte_valid),
    .byte_data  (byte_data)
  );

  fpdx_decode u_decode (
    .clk        (clk),
    .rst_n      (rst_n),
    .byte_valid (byte_valid),
    .byte_data  (byte_data),
    .take       (take),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res)
  );

  fpdx_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .out_ch    (out_ch)
  );

endmodule

// File: sim/tb_framed_packet_decoder_xor.sv
// Testbench for framed_packet_decoder_xor: directed and random byte streams with
// an in-bench frame decoder that predicts every payload and verdict transaction.
// Depends on fpdx_pkg, fpdx_if and the design files under design/.
module tb_framed_packet_decoder_xor;
  import fpdx_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_PCT    = 13;
  localparam int CYCLE_LIMIT = 100000;
  localparam int TAIL_CYCLES = 10;
  localparam int MAX_REPORTS = 10;

  typedef enum logic [2:0] {
    WAIT_START,
    GET_LENGTH,
    GET_PAYLOAD,
    GET_CHECKSUM,
    GET_TERMINATOR
  } frame_phase_t;

  typedef logic [7:0] byte_q_t[$];

  logic clk = 1'b0;
  logic rst_n;

  fpdx_byte_if   byte_ch();
  fpdx_result_if result_ch();

  framed_packet_decoder_xor u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (byte_ch),
    .out_ch (result_ch)
  );

  // Decoder shadow state
  frame_phase_t dec_phase;
  logic [7:0]   dec_length;
  logic [7:0]   dec_count;
  logic [7:0]   dec_xor;
  logic [7:0]   dec_checksum;

  byte_q_t rx_stream_q;
  result_t frame_results_q[$];

  int  cycle_count;
  int  hold_cycle;
  int  mismatch_count;
  logic quiet_window;
  logic out_hold_off;

  always #10 clk = ~clk;

  // Advance the shadow decoder by one accepted byte; queue the result it causes.
  function automatic void decode_rx_byte(input logic [7:0] b);
    result_t r;
    case (dec_phase)
      GET_LENGTH: begin
        dec_length = b;
        dec_count  = 8'h00;
        dec_xor    = 8'h00;
        dec_phase  = (b == 8'h00) ? GET_CHECKSUM : GET_PAYLOAD;
      end
      GET_PAYLOAD: begin
        r.kind       = KIND_PAYLOAD;
        r.data_byte  = b;
        r.byte_index = dec_count;
        r.frame_ok   = 1'b0;
        frame_results_q.push_back(r);
        dec_xor   = dec_xor ^ b;
        dec_count = dec_count + 8'h01;
        if (dec_count == dec_length) dec_phase = GET_CHECKSUM;
      end
      GET_CHECKSUM: begin
        dec_checksum = b;
        dec_phase    = GET_TERMINATOR;
      end
      GET_TERMINATOR: begin
        r.kind       = KIND_VERDICT;
        r.data_byte  = 8'h00;
        r.byte_index = dec_length;
        r.frame_ok   = (b == END_BYTE) && (dec_checksum == dec_xor);
        frame_results_q.push_back(r);
        dec_phase = WAIT_START;
      end
      default: begin
        dec_phase = (b == START_BYTE) ? GET_LENGTH : WAIT_START;
      end
    endcase
  endfunction

  function automatic logic [7:0] xor_of(input byte_q_t body);
    logic [7:0] acc;
    acc = 8'h00;
    foreach (body[i]) acc = acc ^ body[i];
    return acc;
  endfunction

  task automatic push_frame(input byte_q_t body, input logic [7:0] chk,
                            input logic [7:0] term);
    rx_stream_q.push_back(START_BYTE);
    rx_stream_q.push_back(8'(body.size()));
    foreach (body[i]) rx_stream_q.push_back(body[i]);
    rx_stream_q.push_back(chk);
    rx_stream_q.push_back(term);
  endtask

  task automatic check_result(input result_t got);
    result_t want;
    if (frame_results_q.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
        $display("%0t: unexpected result kind=%0d data=%h index=%0d ok=%0d", $realtime,
                 got.kind, got.data_byte, got.byte_index, got.frame_ok);
      return;
    end
    want = frame_results_q.pop_front();
    if (got.kind !== want.kind || got.data_byte !== want.data_byte ||
        got.byte_index !== want.byte_index || got.frame_ok !== want.frame_ok) begin
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS) begin
        $display("%0t: mismatch exp kind=%0d data=%h index=%0d ok=%0d,", $realtime,
                 want.kind, want.data_byte, want.byte_index, want.frame_ok);
        $display("    got kind=%0d data=%h index=%0d ok=%0d",
                 got.kind, got.data_byte, got.byte_index, got.frame_ok);
      end
    end
  endtask

  // Cycle counter; also opens a window with no idling on either side.
  always @(posedge clk) begin
    if (rst_n) cycle_count <= cycle_count + 1;
    quiet_window <= (cycle_count >= 400) && (cycle_count < 560);
  end

  // Long receiver hold-off so the decoder fills up and stalls its input.
  always @(posedge clk) begin
    if (rst_n) hold_cycle <= hold_cycle + 1;
    out_hold_off <= (hold_cycle >= 150) && (hold_cycle < 330);
  end

  // Byte driver
  always @(posedge clk) begin
    if (!rst_n) begin
      byte_ch.valid   <= 1'b0;
      byte_ch.rx_byte <= 8'h00;
      dec_phase       = WAIT_START;
      dec_length      = 8'h00;
      dec_count       = 8'h00;
      dec_xor         = 8'h00;
      dec_checksum    = 8'h00;
    end else begin
      if (byte_ch.valid && byte_ch.ready) decode_rx_byte(byte_ch.rx_byte);
      if (!byte_ch.valid || byte_ch.ready) begin
        if (rx_stream_q.size() != 0 &&
            (quiet_window || $urandom_range(99) >= IDLE_PCT)) begin
          byte_ch.valid   <= 1'b1;
          byte_ch.rx_byte <= rx_stream_q.pop_front();
        end else begin
          byte_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor
  always @(posedge clk) begin
    result_t got;
    if (!rst_n) begin
      result_ch.ready <= 1'b0;
      mismatch_count  = 0;
    end else begin
      if (result_ch.valid && result_ch.ready) begin
        got.kind       = result_ch.result_kind;
        got.data_byte  = result_ch.data_byte;
        got.byte_index = result_ch.byte_index;
        got.frame_ok   = result_ch.frame_ok;
        check_result(got);
      end
      result_ch.ready <= !out_hold_off &&
                         (quiet_window || $urandom_range(99) >= IDLE_PCT);
    end
  end

  initial begin
    byte_q_t    body;
    logic [7:0] chk;
    logic [7:0] term;
    int         len;
    int         burst;
    int         frame_items;
    int         frame_num;
    logic       timed_out;

    rst_n = 1'b0;

    // Idle noise that must be dropped
    rx_stream_q.push_back(8'h00);
    rx_stream_q.push_back(8'hFF);
    // Zero length, checksum 0, good terminator
    body = {};
    push_frame(body, 8'h00, END_BYTE);
    rx_stream_q.push_back(END_BYTE);
    // Start byte as length and as payload
    body = '{START_BYTE, 8'hFF};
    push_frame(body, 8'hFD, END_BYTE);
    // Start byte as checksum, wrong checksum
    body = '{8'h00};
    push_frame(body, START_BYTE, END_BYTE);
    // Start byte as terminator, bad terminator
    body = '{8'h80};
    push_frame(body, 8'h80, START_BYTE);

    // Random frames, mostly well formed, one at maximum length
    frame_items = 0;
    frame_num   = 0;
    while (frame_items < 520) begin
      if ($urandom_range(99) < 18) begin
        burst = $urandom_range(1, 4);
        repeat (burst) rx_stream_q.push_back(8'($urandom));
      end else begin
        if (frame_num == 12) len = 255;
        else if ($urandom_range(99) < 70) len = $urandom_range(0, 6);
        else len = $urandom_range(7, 40);
        body = {};
        repeat (len) body.push_back(8'($urandom));
        chk = xor_of(body);
        if ($urandom_range(99) < 20) chk = 8'($urandom);
        term = ($urandom_range(99) < 85) ? END_BYTE : 8'($urandom);
        push_frame(body, chk, term);
        frame_items += len + 4;
        frame_num++;
      end
    end

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Drain: all bytes sent, all results seen, then a short tail.
    while ((rx_stream_q.size() != 0 || byte_ch.valid || frame_results_q.size() != 0) &&
           cycle_count < CYCLE_LIMIT)
      @(posedge clk);
    timed_out = (cycle_count >= CYCLE_LIMIT);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (timed_out || frame_results_q.size() != 0) begin
      $display("[framed_packet_decoder_xor] ERROR");
    end else if (mismatch_count == 0) begin
      $display("[framed_packet_decoder_xor] OK");
    end else begin
      $display("[framed_packet_decoder_xor] ERROR");
    end
    $finish;
  end

endmodule
